FILE: hw/rtl/dft2d_pkg.sv
package dft2d_pkg;

   // Fixed widths of the configuration registers and the working image size.
   localparam int DIM_W     = 7;
   localparam int CNT_W     = 2 * DIM_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Operand selection for the shared divider.
   typedef enum logic [2:0] {
      DIV_UMOD,
      DIV_VMOD,
      DIV_ROW,
      DIV_COL,
      DIV_RE,
      DIV_IM
   } div_sel_type;

   typedef struct packed {
      logic        idle;
      logic        div_start;
      div_sel_type div_sel;
      logic        scan_init;
      logic        scan_en;
      logic        sq_a;
      logic        sq_b;
      logic        sq_sum;
      logic        root_step;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic query_go;
      logic div_done;
      logic scan_last;
      logic pipe_empty;
      logic root_last;
      logic out_free;
   } dp_status_type;

   // Quarter-wave sine entry: Taylor series in Q30, rounded to tb fraction bits.
   function automatic longint unsigned sine_entry(input int unsigned r,
                                                  input int unsigned pb,
                                                  input int unsigned tb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (HALF_PI_Q30 * 64'(r)) >> (pb - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      return (longint'(sum) + (64'd1 << (29 - tb))) >> (30 - tb);
   endfunction

endpackage

FILE: hw/rtl/dft2d_ram.sv
module dft2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dft2d_div.sv
module dft2d_div #(
   parameter int DVD_W = 40,
   parameter int DSR_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DSR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   shifted;
   logic [DSR_W:0]   trial;
   logic             fits;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/dft2d_datapath.sv
module dft2d_datapath #(
   parameter int MAX_ROWS          = 64,
   parameter int MAX_COLS          = 64,
   parameter int PHASE_BITS        = 10,
   parameter int TWIDDLE_FRAC_BITS = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dft2d_pkg::dp_cmd_type            cmd,
   output dft2d_pkg::dp_status_type         status,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [5:0]                       req_pos_row,
   input  logic [5:0]                       req_pos_col,
   input  logic [7:0]                       req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_magnitude,
   input  logic                             csr_we,
   input  logic [dft2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dft2d_pkg::DIM_W-1:0]      csr_wdata
);

   import dft2d_pkg::*;

   localparam int T       = TWIDDLE_FRAC_BITS;
   localparam int P       = PHASE_BITS;
   localparam int QUARTER = 1 << (P - 2);
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW_W    = T + 2;
   localparam int PRD_W   = TW_W + 9;
   localparam int ACC_W   = CNT_W + 9 + T;
   localparam int ROWD_W  = CNT_W + P;
   localparam int DVD_W   = (ACC_W > ROWD_W) ? ACC_W : ROWD_W;
   localparam int AB_W    = 8 + T;
   localparam int SQ_W    = 2 * AB_W + 1;

   // Configuration and effective image size.
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [DIM_W-1:0] m_eff, n_eff;
   logic [CNT_W-1:0] cnt;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we && csr_index == CSR_NUM_ROWS) begin
         rows_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_NUM_COLS) begin
         cols_in = csr_wdata;
      end
      if (rows_ff == '0) begin
         m_eff = DIM_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         m_eff = DIM_W'(MAX_ROWS);
      end else begin
         m_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         n_eff = DIM_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         n_eff = DIM_W'(MAX_COLS);
      end else begin
         n_eff = cols_ff;
      end
      cnt = m_eff * n_eff;
   end

   // Input transactions: loads write the store directly, queries latch (u, v).
   logic             req_take;
   logic             ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [5:0]       u_ff, u_in;
   logic [5:0]       v_ff, v_in;

   assign req_stall = !cmd.idle;
   assign req_take  = req_valid && cmd.idle;
   assign ram_we    = req_take && req_cmd == CMD_LOAD &&
                      int'(req_pos_row) < MAX_ROWS && int'(req_pos_col) < MAX_COLS;
   assign ram_waddr = ADDR_W'(int'(req_pos_row) * MAX_COLS + int'(req_pos_col));
   assign u_in      = (req_take && req_cmd == CMD_QUERY) ? req_pos_row : u_ff;
   assign v_in      = (req_take && req_cmd == CMD_QUERY) ? req_pos_col : v_ff;

   // Shared divider and its operand selection.
   logic             div_done;
   logic [DVD_W-1:0] div_quo;
   logic [CNT_W-1:0] div_rem;
   logic [DVD_W-1:0] dvd;
   logic [CNT_W-1:0] dsr;
   logic [CNT_W-1:0] row_prod, col_prod;
   logic [DIM_W-1:0] umod_ff, umod_in;
   logic [DIM_W-1:0] vmod_ff, vmod_in;
   logic [P-1:0]     qr_ff, qr_in, qc_ff, qc_in;
   logic [CNT_W-1:0] rr_ff, rr_in, rc_ff, rc_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [ACC_W-1:0] re_abs, im_abs;
   logic [AB_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic             sat_ff, sat_in;

   assign row_prod = umod_ff * n_eff;
   assign col_prod = vmod_ff * m_eff;
   assign re_abs   = acc_re_ff[ACC_W-1] ? ACC_W'(-acc_re_ff) : ACC_W'(acc_re_ff);
   assign im_abs   = acc_im_ff[ACC_W-1] ? ACC_W'(-acc_im_ff) : ACC_W'(acc_im_ff);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_UMOD: begin
            dvd = DVD_W'(u_ff);
            dsr = CNT_W'(m_eff);
         end
         DIV_VMOD: begin
            dvd = DVD_W'(v_ff);
            dsr = CNT_W'(n_eff);
         end
         DIV_ROW: begin
            dvd = DVD_W'({row_prod, {P{1'b0}}});
            dsr = cnt;
         end
         DIV_COL: begin
            dvd = DVD_W'({col_prod, {P{1'b0}}});
            dsr = cnt;
         end
         DIV_RE: begin
            dvd = DVD_W'(re_abs);
            dsr = cnt;
         end
         DIV_IM: begin
            dvd = DVD_W'(im_abs);
            dsr = cnt;
         end
         default: begin
            dvd = '0;
            dsr = cnt;
         end
      endcase
   end

   dft2d_div #(
      .DVD_W (DVD_W),
      .DSR_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      umod_in = umod_ff;
      vmod_in = vmod_ff;
      qr_in   = qr_ff;
      rr_in   = rr_ff;
      qc_in   = qc_ff;
      rc_in   = rc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sat_in  = sat_ff;
      if (div_done) begin
         unique case (cmd.div_sel)
            DIV_UMOD: umod_in = div_rem[DIM_W-1:0];
            DIV_VMOD: vmod_in = div_rem[DIM_W-1:0];
            DIV_ROW: begin
               qr_in = div_quo[P-1:0];
               rr_in = div_rem;
            end
            DIV_COL: begin
               qc_in = div_quo[P-1:0];
               rc_in = div_rem;
            end
            DIV_RE: begin
               a_in   = div_quo[AB_W-1:0];
               sat_in = |div_quo[DVD_W-1:AB_W];
            end
            DIV_IM: begin
               b_in   = div_quo[AB_W-1:0];
               sat_in = sat_ff | (|div_quo[DVD_W-1:AB_W]);
            end
            default: begin
               sat_in = sat_ff;
            end
         endcase
      end
   end

   // Scan over the image: the phase is kept as quotient and remainder of
   // (num * 2^P + cnt/2) / cnt and advanced by precomputed steps.
   logic [DIM_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [P-1:0]      colq_ff, colq_in, rowq_ff, rowq_in;
   logic [CNT_W-1:0]  colr_ff, colr_in, rowr_ff, rowr_in;
   logic [CNT_W:0]    col_sum, row_sum;
   logic              col_wrap, row_wrap;
   logic [P-1:0]      colq_nx, rowq_nx;
   logic [CNT_W-1:0]  colr_nx, rowr_nx;
   logic              row_end;
   logic [ADDR_W-1:0] rd_addr;

   assign col_sum  = {1'b0, colr_ff} + {1'b0, rc_ff};
   assign col_wrap = col_sum >= {1'b0, cnt};
   assign colr_nx  = col_wrap ? CNT_W'(col_sum - {1'b0, cnt}) : col_sum[CNT_W-1:0];
   assign colq_nx  = colq_ff + qc_ff + P'(col_wrap);
   assign row_sum  = {1'b0, rowr_ff} + {1'b0, rr_ff};
   assign row_wrap = row_sum >= {1'b0, cnt};
   assign rowr_nx  = row_wrap ? CNT_W'(row_sum - {1'b0, cnt}) : row_sum[CNT_W-1:0];
   assign rowq_nx  = rowq_ff + qr_ff + P'(row_wrap);
   assign row_end  = j_ff == n_eff - 1'b1;
   assign rd_addr  = base_ff + ADDR_W'(j_ff);

   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      base_in = base_ff;
      colq_in = colq_ff;
      colr_in = colr_ff;
      rowq_in = rowq_ff;
      rowr_in = rowr_ff;
      if (cmd.scan_init) begin
         i_in    = '0;
         j_in    = '0;
         base_in = '0;
         colq_in = '0;
         rowq_in = '0;
         colr_in = cnt >> 1;
         rowr_in = cnt >> 1;
      end else if (cmd.scan_en) begin
         if (row_end) begin
            j_in    = '0;
            i_in    = i_ff + 1'b1;
            base_in = base_ff + ADDR_W'(MAX_COLS);
            rowq_in = rowq_nx;
            rowr_in = rowr_nx;
            colq_in = rowq_nx;
            colr_in = rowr_nx;
         end else begin
            j_in    = j_ff + 1'b1;
            colq_in = colq_nx;
            colr_in = colr_nx;
         end
      end
   end

   logic [7:0] rd_data;

   dft2d_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_pixel_value),
      .rd_en   (cmd.scan_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Twiddle table and multiply-accumulate pipeline.
   logic [T:0] sine_tab [0:QUARTER];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
      localparam longint unsigned SINE_VAL = sine_entry(g, P, T);
      assign sine_tab[g] = SINE_VAL[T:0];
   end

   logic                     v1_ff, v2_ff, v3_ff;
   logic [P-1:0]             k1_ff;
   logic [1:0]               quad;
   logic [P-2:0]             r_idx, rq_idx;
   logic signed [TW_W-1:0]   sr, cr, c_in, s_in, c_ff, s_ff;
   logic [7:0]               px_ff;
   logic signed [8:0]        px_s;
   logic signed [PRD_W-1:0]  pre_ff, pim_ff;

   assign quad   = k1_ff[P-1:P-2];
   assign r_idx  = {1'b0, k1_ff[P-3:0]};
   assign rq_idx = (P-1)'(QUARTER) - r_idx;
   assign sr     = signed'({1'b0, sine_tab[r_idx]});
   assign cr     = signed'({1'b0, sine_tab[rq_idx]});
   assign px_s   = signed'({1'b0, px_ff});

   always_comb begin
      unique case (quad)
         2'd0: begin
            c_in = cr;
            s_in = sr;
         end
         2'd1: begin
            c_in = -sr;
            s_in = cr;
         end
         2'd2: begin
            c_in = -cr;
            s_in = -sr;
         end
         default: begin
            c_in = sr;
            s_in = -cr;
         end
      endcase
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (cmd.scan_init) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v3_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(pre_ff);
         acc_im_in = acc_im_ff + ACC_W'(pim_ff);
      end
   end

   // Magnitude: squares, then an 8-step bitwise square-root search.
   logic [SQ_W-1:0]   a2_ff, b2_ff, sum_ff;
   logic [7:0]        res_ff, res_in, bit_ff, bit_in;
   logic [7:0]        cand;
   logic [15:0]       cand_sq;
   logic [SQ_W-1:0]   thresh;
   logic [7:0]        mag;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_mag_ff;

   assign cand    = res_ff | bit_ff;
   assign cand_sq = cand * cand;
   assign thresh  = SQ_W'({cand_sq, {(2 * T){1'b0}}});
   assign mag     = sat_ff ? 8'hFF : res_ff;

   always_comb begin
      res_in = res_ff;
      bit_in = bit_ff;
      if (cmd.sq_a) begin
         res_in = '0;
         bit_in = 8'h80;
      end else if (cmd.root_step) begin
         if (sum_ff >= thresh) begin
            res_in = cand;
         end
         bit_in = bit_ff >> 1;
      end
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_W'(64);
         cols_ff      <= DIM_W'(64);
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         v1_ff        <= cmd.scan_en;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff      <= u_in;
      v_ff      <= v_in;
      umod_ff   <= umod_in;
      vmod_ff   <= vmod_in;
      qr_ff     <= qr_in;
      rr_ff     <= rr_in;
      qc_ff     <= qc_in;
      rc_ff     <= rc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      sat_ff    <= sat_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      base_ff   <= base_in;
      colq_ff   <= colq_in;
      colr_ff   <= colr_in;
      rowq_ff   <= rowq_in;
      rowr_ff   <= rowr_in;
      k1_ff     <= colq_ff;
      c_ff      <= c_in;
      s_ff      <= s_in;
      px_ff     <= rd_data;
      pre_ff    <= px_s * c_ff;
      pim_ff    <= px_s * s_ff;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      res_ff    <= res_in;
      if (cmd.sq_a) begin
         a2_ff <= SQ_W'(a_ff * a_ff);
      end
      if (cmd.sq_b) begin
         b2_ff <= SQ_W'(b_ff * b_ff);
      end
      if (cmd.sq_sum) begin
         sum_ff <= a2_ff + b2_ff;
      end
      if (cmd.out_load) begin
         rsp_mag_ff <= mag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;

   assign status.query_go   = req_take && req_cmd == CMD_QUERY;
   assign status.div_done   = div_done;
   assign status.scan_last  = row_end && i_ff == m_eff - 1'b1;
   assign status.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign status.root_last  = bit_ff[0];
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // The phase remainder must stay a proper remainder throughout the scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en |-> colr_ff < cnt && rowr_ff < cnt)
      else $error("phase remainder out of range during scan");

   // Pixels are only written while no query is in progress.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> cmd.idle && !v1_ff && !v3_ff)
      else $error("store written during a query");

   // The root search walks a single bit downward.
   assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |=> $onehot0(bit_ff))
      else $error("root search bit is not one-hot");

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result overwritten before it was taken");

endmodule

FILE: hw/rtl/dft2d_ctrl.sv
module dft2d_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  dft2d_pkg::dp_status_type  status,
   output dft2d_pkg::dp_cmd_type     cmd
);

   import dft2d_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MOD_U     = 4'd1;
   localparam logic [3:0] S_MOD_V     = 4'd2;
   localparam logic [3:0] S_DIV_ROW   = 4'd3;
   localparam logic [3:0] S_DIV_COL   = 4'd4;
   localparam logic [3:0] S_SCAN_INIT = 4'd5;
   localparam logic [3:0] S_SCAN      = 4'd6;
   localparam logic [3:0] S_DRAIN     = 4'd7;
   localparam logic [3:0] S_DIV_RE    = 4'd8;
   localparam logic [3:0] S_DIV_IM    = 4'd9;
   localparam logic [3:0] S_SQ_A      = 4'd10;
   localparam logic [3:0] S_SQ_B      = 4'd11;
   localparam logic [3:0] S_SQ_SUM    = 4'd12;
   localparam logic [3:0] S_ROOT      = 4'd13;
   localparam logic [3:0] S_DONE      = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       div_go_ff, div_go_in;
   logic       div_state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (status.query_go) state_in = S_MOD_U;
         S_MOD_U:     if (status.div_done) state_in = S_MOD_V;
         S_MOD_V:     if (status.div_done) state_in = S_DIV_ROW;
         S_DIV_ROW:   if (status.div_done) state_in = S_DIV_COL;
         S_DIV_COL:   if (status.div_done) state_in = S_SCAN_INIT;
         S_SCAN_INIT: state_in = S_SCAN;
         S_SCAN:      if (status.scan_last) state_in = S_DRAIN;
         S_DRAIN:     if (status.pipe_empty) state_in = S_DIV_RE;
         S_DIV_RE:    if (status.div_done) state_in = S_DIV_IM;
         S_DIV_IM:    if (status.div_done) state_in = S_SQ_A;
         S_SQ_A:      state_in = S_SQ_B;
         S_SQ_B:      state_in = S_SQ_SUM;
         S_SQ_SUM:    state_in = S_ROOT;
         S_ROOT:      if (status.root_last) state_in = S_DONE;
         S_DONE:      if (status.out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      div_state_in = state_in == S_MOD_U || state_in == S_MOD_V ||
                     state_in == S_DIV_ROW || state_in == S_DIV_COL ||
                     state_in == S_DIV_RE || state_in == S_DIV_IM;
      div_go_in = div_state_in && state_in != state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         div_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= div_go_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_MOD_U:   cmd.div_sel = DIV_UMOD;
         S_MOD_V:   cmd.div_sel = DIV_VMOD;
         S_DIV_ROW: cmd.div_sel = DIV_ROW;
         S_DIV_COL: cmd.div_sel = DIV_COL;
         S_DIV_RE:  cmd.div_sel = DIV_RE;
         default:   cmd.div_sel = DIV_IM;
      endcase
      cmd.idle      = state_ff == S_IDLE;
      cmd.div_start = div_go_ff;
      cmd.scan_init = state_ff == S_SCAN_INIT;
      cmd.scan_en   = state_ff == S_SCAN;
      cmd.sq_a      = state_ff == S_SQ_A;
      cmd.sq_b      = state_ff == S_SQ_B;
      cmd.sq_sum    = state_ff == S_SQ_SUM;
      cmd.root_step = state_ff == S_ROOT;
      cmd.out_load  = state_ff == S_DONE && status.out_free;
   end

endmodule

FILE: hw/rtl/dft2d_magnitude_unit.sv
// Magnitude of one bin of the 2-D DFT of an 8-bit grey image held in an internal
// MAX_ROWS x MAX_COLS pixel store. A load transaction (cmd 0) writes one pixel and
// returns nothing. A query transaction (cmd 1) names a frequency pair (u, v) and
// returns floor(|F(u,v)| / (M*N)), saturated at 255, where M and N come from the
// num_rows and num_cols registers. The block handles one query at a time: the
// image scan reads one pixel per cycle through the store's single read port, and
// a shared bit-serial divider, DVD_W bits wide (T+23 bits for T twiddle fraction
// bits), sets up the phase steps and normalizes the two sums. Loads are accepted
// only between queries, and every pixel inside M x N must be loaded before the
// first query. A result waiting on a stalled output does not block new loads or
// the start of the next query.
module dft2d_magnitude_unit #(
   parameter int MAX_ROWS          = 64,
   parameter int MAX_COLS          = 64,
   parameter int PHASE_BITS        = 10,
   parameter int TWIDDLE_FRAC_BITS = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [5:0]                       req_pos_row,
   input  logic [5:0]                       req_pos_col,
   input  logic [7:0]                       req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_magnitude,
   input  logic                             csr_we,
   input  logic [dft2d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dft2d_pkg::DIM_W-1:0]      csr_wdata
);

   import dft2d_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   dft2d_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   dft2d_datapath #(
      .MAX_ROWS          (MAX_ROWS),
      .MAX_COLS          (MAX_COLS),
      .PHASE_BITS        (PHASE_BITS),
      .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_row     (req_pos_row),
      .req_pos_col     (req_pos_col),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_magnitude   (rsp_magnitude),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

FILE: verif/dft2d_magnitude_checker.sv
`timescale 1ns / 1ps

module dft2d_magnitude_checker #(
   parameter int MAX_ROWS          = 64,
   parameter int MAX_COLS          = 64,
   parameter int PHASE_BITS        = 10,
   parameter int TWIDDLE_FRAC_BITS = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [5:0]                      req_pos_row,
   input  logic [5:0]                      req_pos_col,
   input  logic [7:0]                      req_pixel_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [7:0]                      rsp_magnitude,
   input  logic                            csr_we,
   input  logic [dft2d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dft2d_pkg::DIM_W-1:0]     csr_wdata,
   output int                              errors,
   output int                              pending
);

   import dft2d_pkg::*;

   localparam int QTR = 1 << (PHASE_BITS - 2);

   logic [7:0]      image [MAX_ROWS*MAX_COLS];
   logic [DIM_W-1:0] rows_reg;
   logic [DIM_W-1:0] cols_reg;
   longint          quarter_sine [QTR+1];
   logic [7:0]      magnitudes_due [$];

   // Quarter-wave sine in Q30 from a truncated Taylor series, then rounded.
   function automatic longint sine_of_step(int unsigned r);
      longint unsigned x, x2, term;
      longint          acc;
      x    = (64'd1686629713 * 64'(r)) >> (PHASE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc -= longint'(term);
         end else begin
            acc += longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return (acc + (64'd1 << (29 - TWIDDLE_FRAC_BITS))) >>> (30 - TWIDDLE_FRAC_BITS);
   endfunction

   function automatic longint unsigned clamp_dim(logic [DIM_W-1:0] raw, int unsigned top);
      if (raw == 0) begin
         return 1;
      end
      return (raw > top) ? top : raw;
   endfunction

   function automatic logic [7:0] spectrum_magnitude(longint unsigned u, longint unsigned v);
      longint unsigned m, n, cnt, num, k, a, b, a2, b2, t, cand, lim;
      longint          re, im, cs, sn, px;
      logic [7:0]      res;
      m   = clamp_dim(rows_reg, MAX_ROWS);
      n   = clamp_dim(cols_reg, MAX_COLS);
      cnt = m * n;
      re  = 0;
      im  = 0;
      for (longint unsigned i = 0; i < m; i++) begin
         for (longint unsigned j = 0; j < n; j++) begin
            num = ((u * i) % m) * n + ((v * j) % n) * m;
            k   = (((num << PHASE_BITS) + cnt / 2) / cnt) & ((64'd1 << PHASE_BITS) - 1);
            case (k >> (PHASE_BITS - 2))
               0: begin cs =  quarter_sine[QTR - (k % QTR)]; sn =  quarter_sine[k % QTR]; end
               1: begin cs = -quarter_sine[k % QTR]; sn =  quarter_sine[QTR - (k % QTR)]; end
               2: begin cs = -quarter_sine[QTR - (k % QTR)]; sn = -quarter_sine[k % QTR]; end
               default: begin
                  cs =  quarter_sine[k % QTR];
                  sn = -quarter_sine[QTR - (k % QTR)];
               end
            endcase
            px = longint'(image[i * MAX_COLS + j]);
            re += px * cs;
            im += px * sn;
         end
      end
      a   = longint'(re < 0 ? -re : re) / cnt;
      b   = longint'(im < 0 ? -im : im) / cnt;
      lim = 64'd256 << TWIDDLE_FRAC_BITS;
      if (a >= lim || b >= lim) begin
         return 8'd255;
      end
      a2  = a * a;
      b2  = b * b;
      res = 0;
      for (int bit_pos = 7; bit_pos >= 0; bit_pos--) begin
         cand = longint'(res | (8'd1 << bit_pos));
         t    = (cand << TWIDDLE_FRAC_BITS) * (cand << TWIDDLE_FRAC_BITS);
         if (a2 + b2 >= t) begin
            res = cand[7:0];
         end
      end
      return res;
   endfunction

   task automatic report(string what, int exp_val, int got_val);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
      errors++;
   endtask

   initial begin
      errors = 0;
      for (int r = 0; r <= QTR; r++) begin
         quarter_sine[r] = sine_of_step(r);
      end
      foreach (image[i]) begin
         image[i] = '0;
      end
   end

   assign pending = magnitudes_due.size();

   always @(posedge clock) begin
      if (reset) begin
         rows_reg = 7'd64;
         cols_reg = 7'd64;
         magnitudes_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_ROWS) begin
               rows_reg = csr_wdata;
            end else if (csr_index == CSR_NUM_COLS) begin
               cols_reg = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (magnitudes_due.size() == 0) begin
               report("unexpected magnitude", -1, rsp_magnitude);
            end else begin
               if (rsp_magnitude !== magnitudes_due[0]) begin
                  report("magnitude", magnitudes_due[0], rsp_magnitude);
               end
               void'(magnitudes_due.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_LOAD) begin
               image[req_pos_row * MAX_COLS + req_pos_col] = req_pixel_value;
            end else begin
               magnitudes_due.push_back(spectrum_magnitude(req_pos_row, req_pos_col));
            end
         end
      end
   end

endmodule

FILE: verif/tb_dft2d_magnitude_unit.sv
`timescale 1ns / 1ps

module tb_dft2d_magnitude_unit;
   import dft2d_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 60;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_cmd;
   logic [5:0]       req_pos_row;
   logic [5:0]       req_pos_col;
   logic [7:0]       req_pixel_value;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [7:0]       rsp_magnitude;
   logic             csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_wdata;
   int               errors;
   int               pending;
   int               cycles = 0;
   int               burst_left;
   bit               hold_go;
   bit               loaded [64*64];
   int               eff_rows;
   int               eff_cols;

   dft2d_magnitude_unit dut (.*);

   dft2d_magnitude_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver switches between random stall densities at random intervals;
   // one long hold-off lets the block back up onto its input.
   initial begin
      int density;
      rsp_stall = 0;
      forever begin
         if (hold_go) begin
            hold_go = 0;
            repeat (1500) begin
               @(posedge clock);
               rsp_stall <= 1;
            end
         end
         density = $urandom_range(0, 3) * 30;
         repeat ($urandom_range(16, 80)) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < density);
         end
      end
   end

   task automatic send(logic cmd, logic [5:0] row, logic [5:0] col, logic [7:0] pix);
      req_valid       <= 1;
      req_cmd         <= cmd;
      req_pos_row     <= row;
      req_pos_col     <= col;
      req_pixel_value <= pix;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (cmd == CMD_LOAD) begin
         loaded[row * 64 + col] = 1;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_NUM_ROWS) begin
         eff_rows = (val == 0) ? 1 : (val > 64 ? 64 : val);
      end else if (idx == CSR_NUM_COLS) begin
         eff_cols = (val == 0) ? 1 : (val > 64 ? 64 : val);
      end
   endtask

   task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
      drain();
      write_reg(CSR_NUM_ROWS, r);
      write_reg(CSR_NUM_COLS, c);
   endtask

   // Every pixel a query scans must have been loaded at least once.
   task automatic fill_missing(bit all_max);
      for (int i = 0; i < eff_rows; i++) begin
         for (int j = 0; j < eff_cols; j++) begin
            if (!loaded[i * 64 + j] || all_max) begin
               send(CMD_LOAD, 6'(i), 6'(j), all_max ? 8'd255 : 8'($urandom));
            end
         end
      end
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int r_dim, c_dim;
      req_valid       = 0;
      req_cmd         = CMD_LOAD;
      req_pos_row     = 0;
      req_pos_col     = 0;
      req_pixel_value = 0;
      csr_we          = 0;
      csr_index       = CSR_NUM_ROWS;
      csr_wdata       = 0;
      burst_left      = 0;
      hold_go         = 0;
      eff_rows        = 64;
      eff_cols        = 64;
      reset           = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: one-pixel image, extremes of the pixel and of the frequencies.
      write_reg(CSR_NUM_ROWS, 7'd1);
      write_reg(CSR_NUM_COLS, 7'd1);
      write_reg(CSR_SPARE, 7'd5);
      send(CMD_LOAD, 0, 0, 8'd255);
      send(CMD_QUERY, 0, 0, 8'd0);
      send(CMD_QUERY, 63, 63, 8'd255);
      send(CMD_LOAD, 0, 0, 8'd0);
      send(CMD_QUERY, 0, 0, 8'd0);
      // A zero dimension behaves as one.
      set_dims(7'd0, 7'd0);
      send(CMD_LOAD, 0, 0, 8'd128);
      send(CMD_QUERY, 1, 1, 8'd0);
      // Flat bright image drives the DC bin to 255; frequencies past M and N wrap.
      set_dims(7'd2, 7'd3);
      fill_missing(1);
      send(CMD_QUERY, 0, 0, 8'd0);
      send(CMD_QUERY, 1, 1, 8'd0);
      send(CMD_QUERY, 2, 3, 8'd0);
      // A load outside M x N but inside the store is kept.
      send(CMD_LOAD, 63, 63, 8'd170);
      send(CMD_LOAD, 1, 2, 8'd7);
      send(CMD_QUERY, 0, 1, 8'd0);
      // A dimension above the store size is clipped.
      set_dims(7'd127, 7'd1);
      fill_missing(0);
      send(CMD_QUERY, 32, 0, 8'd0);
      send(CMD_QUERY, 63, 5, 8'd0);

      for (int phase = 0; phase < 6; phase++) begin
         r_dim = $urandom_range(0, 4);
         c_dim = $urandom_range(0, 4);
         set_dims(7'(r_dim), 7'(c_dim));
         fill_missing(0);
         if (phase == 3) begin
            hold_go = 1;
         end
         for (int n = 0; n < 8; n++) begin
            if (phase == 3 || $urandom_range(0, 1) == 1) begin
               send(CMD_QUERY, 6'($urandom), 6'($urandom), 8'($urandom));
            end else begin
               send(CMD_LOAD, 6'($urandom), 6'($urandom), rand_pixel());
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
